@@ rtl/core/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and codes for the connection slot table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam logic [2:0] CMD_PUBLISH  = 3'd0;
  localparam logic [2:0] CMD_FIND     = 3'd1;
  localparam logic [2:0] CMD_ASSOC    = 3'd2;
  localparam logic [2:0] CMD_REMOVE   = 3'd3;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd4;
  localparam logic [2:0] CMD_INIT     = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVAL_ARG = 2'd1;
  localparam logic [1:0] ST_INVAL_ST  = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  localparam logic [1:0] ES_FREE      = 2'd0;
  localparam logic [1:0] ES_PENDING   = 2'd1;
  localparam logic [1:0] ES_ASSOC     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FREE,
    S_LK_RD,
    S_LK_CMP,
    S_SH_RD,
    S_SH_CMP
  } cst_state_t;

  typedef enum logic [1:0] {
    EK_PLAIN,
    EK_PUBLISH,
    EK_ENTRY
  } emit_kind_t;

  typedef struct packed {
    logic       load_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       free_take;
    logic       key_init;
    logic       key_step;
    logic       shn_inc;
    logic       pub_commit;
    logic       assoc_commit;
    logic       rem_commit;
    logic       shut_commit;
    logic       init_commit;
    logic       emit;
    emit_kind_t kind;
    logic [1:0] status;
    logic       found;
    logic       close;
    logic       last;
    logic       force_assoc;
  } cst_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       active;
    logic       id_zero;
    logic       tv;
    logic       flags_ok;
    logic       full;
    logic       scan_end;
    logic       slot_live;
    logic       slot_pending;
    logic       key_hit;
    logic       coll_over;
    logic       shut_room;
    logic       out_free;
  } cst_status_t;

endpackage

@@ rtl/core/cst_ctrl.sv @@
// ----------------------------------------------------------------------------
// cst_ctrl
// Command sequencer: decodes a request and walks the slot scans.
// ----------------------------------------------------------------------------
module cst_ctrl
  import cst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cst_status_t sts,
  output cst_cmd_t    cmd
);

  cst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_PUBLISH: begin
            if (!sts.tv || !sts.active || !sts.flags_ok || sts.full) begin
              if (sts.out_free) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FREE;
            end
          end
          CMD_FIND, CMD_ASSOC: begin
            if (!sts.active || sts.id_zero) begin
              if (sts.out_free) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_LK_RD;
            end
          end
          CMD_REMOVE: begin
            if (sts.id_zero || !sts.active) begin
              if (sts.out_free) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_LK_RD;
            end
          end
          CMD_SHUTDOWN: begin
            if (!sts.active) begin
              if (sts.out_free) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SH_RD;
            end
          end
          default: begin
            if (sts.out_free) state_nxt = S_IDLE;
          end
        endcase
      end
      S_FREE: begin
        if (sts.scan_end) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else if (!sts.slot_live) begin
          state_nxt = S_LK_RD;
        end
      end
      S_LK_RD: begin
        if (sts.scan_end) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (!sts.key_hit) begin
          state_nxt = S_LK_RD;
        end else if (sts.cmd == CMD_PUBLISH && !sts.coll_over) begin
          state_nxt = S_LK_RD;
        end else if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SH_RD: begin
        if (sts.scan_end || !sts.shut_room) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SH_CMP;
        end
      end
      S_SH_CMP: begin
        if (!sts.slot_live || sts.out_free) state_nxt = S_SH_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.kind    = EK_PLAIN;
    cmd.last    = 1'b1;
    cmd.load_in = in_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_PUBLISH: begin
            if (!sts.tv) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ARG;
            end else if (!sts.active) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ST;
            end else if (!sts.flags_ok) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ARG;
            end else if (sts.full) begin
              cmd.emit = sts.out_free; cmd.status = ST_LIMIT;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          CMD_FIND: begin
            if (!sts.active || sts.id_zero) begin
              cmd.emit = sts.out_free; cmd.status = ST_OK;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          CMD_ASSOC: begin
            if (!sts.active || sts.id_zero) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ARG;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (sts.id_zero) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ARG;
            end else if (!sts.active) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ST;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          CMD_SHUTDOWN: begin
            if (!sts.active) begin
              cmd.emit = sts.out_free; cmd.status = ST_INVAL_ST;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          CMD_INIT: begin
            cmd.emit = sts.out_free;
            if (sts.active) begin
              cmd.status = ST_INVAL_ST;
            end else begin
              cmd.status      = ST_OK;
              cmd.init_commit = sts.out_free;
            end
          end
          default: begin
            cmd.emit = sts.out_free; cmd.status = ST_INVAL_ARG;
          end
        endcase
      end
      S_FREE: begin
        if (sts.scan_end) begin
          cmd.emit = sts.out_free; cmd.status = ST_INVAL_ST;
        end else if (!sts.slot_live) begin
          cmd.free_take = 1'b1;
          cmd.key_init  = 1'b1;
          cmd.idx_clr   = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LK_RD: begin
        if (sts.scan_end) begin
          cmd.emit = sts.out_free;
          unique case (sts.cmd)
            CMD_PUBLISH: begin
              cmd.kind       = EK_PUBLISH;
              cmd.status     = ST_OK;
              cmd.pub_commit = sts.out_free;
            end
            CMD_FIND: cmd.status = ST_OK;
            default:  cmd.status = ST_INVAL_ARG;
          endcase
        end
      end
      S_LK_CMP: begin
        if (!sts.key_hit) begin
          cmd.idx_inc = 1'b1;
        end else begin
          unique case (sts.cmd)
            CMD_PUBLISH: begin
              if (sts.coll_over) begin
                cmd.emit = sts.out_free; cmd.status = ST_LIMIT;
              end else begin
                cmd.key_step = 1'b1;
                cmd.idx_clr  = 1'b1;
              end
            end
            CMD_FIND: begin
              cmd.emit  = sts.out_free;
              cmd.kind  = EK_ENTRY;
              cmd.found = 1'b1;
            end
            CMD_ASSOC: begin
              cmd.emit = sts.out_free;
              cmd.kind = EK_ENTRY;
              if (!sts.slot_pending || !sts.tv) begin
                cmd.status = ST_INVAL_ST;
              end else begin
                cmd.force_assoc  = 1'b1;
                cmd.assoc_commit = sts.out_free;
              end
            end
            default: begin
              cmd.emit       = sts.out_free;
              cmd.kind       = EK_ENTRY;
              cmd.close      = 1'b1;
              cmd.rem_commit = sts.out_free;
            end
          endcase
        end
      end
      S_SH_RD: begin
        if (sts.scan_end || !sts.shut_room) begin
          cmd.emit        = sts.out_free;
          cmd.shut_commit = sts.out_free;
        end
      end
      S_SH_CMP: begin
        if (!sts.slot_live) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.emit    = sts.out_free;
          cmd.kind    = EK_ENTRY;
          cmd.close   = 1'b1;
          cmd.last    = 1'b0;
          cmd.shn_inc = sts.out_free;
          cmd.idx_inc = sts.out_free;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/cst_datapath.sv @@
// ----------------------------------------------------------------------------
// cst_datapath
// Slot storage, id/context memories, scan counters and the result register.
// ----------------------------------------------------------------------------
module cst_datapath
  import cst_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_conn_id,
  input  logic [63:0] in_context_data,
  input  logic        in_transport_valid,
  input  logic        in_local_endpoint_ok,
  input  logic        in_remote_endpoint_ok,
  input  logic        in_family_match,
  input  cst_cmd_t    cmd,
  output cst_status_t sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_slot_index,
  output logic [1:0]  out_entry_state,
  output logic [31:0] out_result_id,
  output logic [63:0] out_result_context,
  output logic        out_close_transport,
  output logic        out_last
);

  localparam int CW      = $clog2(SLOTS + 1);
  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMPW    = ((CW > 5) ? CW : 5) + 1;
  localparam int IDX     = (ID_WIDTH > 32) ? ID_WIDTH : 32;
  localparam int SXW     = (IW > 4) ? IW : 4;
  localparam int CAP_RST = (SLOTS < 16) ? SLOTS : 16;

  logic [2:0]          cmd_r;
  logic [ID_WIDTH-1:0] key_r;
  logic [63:0]         ctx_r;
  logic                tv_r;
  logic                fok_r;
  logic [4:0]          capacity_r;
  logic [CW-1:0]       cap_r;
  logic [CW-1:0]       live_r;
  logic [ID_WIDTH-1:0] next_id_r;
  logic                active_r;
  logic [CW-1:0]       idx_r;
  logic [IW-1:0]       free_r;
  logic [CW:0]         coll_r;
  logic [4:0]          shn_r;
  logic [1:0]          slot_state_r [SLOTS];
  logic [ID_WIDTH-1:0] id_mem [SLOTS];
  logic [63:0]         ctx_mem [SLOTS];
  logic [ID_WIDTH-1:0] id_rd_r;
  logic [63:0]         ctx_rd_r;
  logic                out_valid_r;

  logic [IW-1:0]       idx_a;
  logic [IDX-1:0]      in_id_ext;
  logic [ID_WIDTH-1:0] cand_init;
  logic [ID_WIDTH-1:0] key_inc;
  logic [ID_WIDTH-1:0] next_inc;
  logic [CMPW-1:0]     cap_ext;
  logic [CW-1:0]       cap_clamp;
  logic [1:0]          cur_state;
  logic [SXW-1:0]      slot_ext;
  logic [SXW-1:0]      free_ext;
  logic [IDX-1:0]      rd_id_ext;
  logic [IDX-1:0]      key_ext;

  assign idx_a     = idx_r[IW-1:0];
  assign in_id_ext = IDX'(in_conn_id);
  assign cand_init = (next_id_r == '0) ? ID_WIDTH'(1) : next_id_r;
  assign key_inc   = ((key_r + ID_WIDTH'(1)) == '0) ? ID_WIDTH'(1) : key_r + ID_WIDTH'(1);
  assign next_inc  = key_inc;
  assign cap_ext   = CMPW'(capacity_r);
  assign cap_clamp = (cap_ext > CMPW'(SLOTS)) ? CW'(SLOTS) : CW'(cap_ext);
  assign cur_state = slot_state_r[idx_a];
  assign slot_ext  = SXW'(idx_a);
  assign free_ext  = SXW'(free_r);
  assign rd_id_ext = IDX'(id_rd_r);
  assign key_ext   = IDX'(key_r);

  always_comb begin
    sts              = '0;
    sts.cmd          = cmd_r;
    sts.active       = active_r;
    sts.id_zero      = (key_r == '0);
    sts.tv           = tv_r;
    sts.flags_ok     = fok_r;
    sts.full         = (live_r >= cap_r);
    sts.scan_end     = (idx_r >= cap_r);
    sts.slot_live    = (cur_state != ES_FREE);
    sts.slot_pending = (cur_state == ES_PENDING);
    sts.key_hit      = (cur_state != ES_FREE) && (id_rd_r == key_r);
    sts.coll_over    = (coll_r >= {1'b0, live_r});
    sts.shut_room    = !shn_r[4];
    sts.out_free     = !out_valid_r || out_ready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      ctx_r <= in_context_data;
      tv_r  <= in_transport_valid;
      fok_r <= in_local_endpoint_ok && in_remote_endpoint_ok && in_family_match;
    end
    if (cmd.load_in) begin
      key_r <= in_id_ext[ID_WIDTH-1:0];
    end else if (cmd.key_init) begin
      key_r <= cand_init;
    end else if (cmd.key_step) begin
      key_r <= key_inc;
    end
    if (cmd.free_take) free_r <= idx_a;
    if (cmd.key_init) begin
      coll_r <= '0;
    end else if (cmd.key_step) begin
      coll_r <= coll_r + (CW+1)'(1);
    end
    if (cmd.load_in) begin
      shn_r <= '0;
    end else if (cmd.shn_inc) begin
      shn_r <= shn_r + 5'd1;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 5'd16;
      cap_r      <= CW'(CAP_RST);
      live_r     <= '0;
      next_id_r  <= ID_WIDTH'(1);
      active_r   <= 1'b1;
      for (int i = 0; i < SLOTS; i++) slot_state_r[i] <= ES_FREE;
    end else begin
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      if (cmd.init_commit || cmd.shut_commit) begin
        for (int i = 0; i < SLOTS; i++) slot_state_r[i] <= ES_FREE;
        live_r <= '0;
      end
      if (cmd.init_commit) begin
        cap_r     <= cap_clamp;
        next_id_r <= ID_WIDTH'(1);
        active_r  <= 1'b1;
      end
      if (cmd.shut_commit) begin
        next_id_r <= '0;
        active_r  <= 1'b0;
      end
      if (cmd.pub_commit) begin
        slot_state_r[free_r] <= ES_PENDING;
        live_r               <= live_r + CW'(1);
        next_id_r            <= next_inc;
      end
      if (cmd.assoc_commit) slot_state_r[idx_a] <= ES_ASSOC;
      if (cmd.rem_commit) begin
        slot_state_r[idx_a] <= ES_FREE;
        if (live_r != '0) live_r <= live_r - CW'(1);
      end
    end
  end

  // id and context memories
  always_ff @(posedge clk) begin
    if (cmd.pub_commit) begin
      id_mem[free_r]  <= key_r;
      ctx_mem[free_r] <= ctx_r;
    end
    id_rd_r  <= id_mem[idx_a];
    ctx_rd_r <= ctx_mem[idx_a];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status          <= cmd.status;
      out_found           <= cmd.found;
      out_close_transport <= cmd.close;
      out_last            <= cmd.last;
      case (cmd.kind)
        EK_PUBLISH: begin
          out_slot_index     <= free_ext[3:0];
          out_entry_state    <= ES_PENDING;
          out_result_id      <= key_ext[31:0];
          out_result_context <= ctx_r;
        end
        EK_ENTRY: begin
          out_slot_index     <= slot_ext[3:0];
          out_entry_state    <= cmd.force_assoc ? ES_ASSOC : cur_state;
          out_result_id      <= rd_id_ext[31:0];
          out_result_context <= ctx_rd_r;
        end
        default: begin
          out_slot_index     <= '0;
          out_entry_state    <= ES_FREE;
          out_result_id      <= '0;
          out_result_context <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/connection_slot_table_unit.sv @@
// ----------------------------------------------------------------------------
// connection_slot_table_unit
// Connection table of fixed slots: publish, find, associate, remove,
// shutdown and init requests over a valid/ready channel.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only while idle. A new
// request may be taken while the last result still waits in the output
// register. Each result leaves through one registered valid/ready stage.
// The slot scan reads the id memory one slot at a time, each slot in a read
// state and then a compare state (S_LK_RD, S_LK_CMP; S_SH_RD, S_SH_CMP):
//   rejected early, init or unknown code: answered from decode, no scan
//   find / associate / remove: one lookup scan over the capacity in use
//   publish: a free-slot scan, then a lookup scan, repeated per id collision
//   shutdown: one result per live slot plus a final one
// A stalled receiver holds the block in place; nothing is dropped.
// Reset empties the table, sets capacity to 16 (clamped to SLOTS), the next
// id to one and makes the table active; no clearing pass is needed. The
// capacity register is taken into the table only by init.
// ----------------------------------------------------------------------------
module connection_slot_table_unit
  import cst_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_conn_id,
  input  logic [63:0] in_context_data,
  input  logic        in_transport_valid,
  input  logic        in_local_endpoint_ok,
  input  logic        in_remote_endpoint_ok,
  input  logic        in_family_match,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_slot_index,
  output logic [1:0]  out_entry_state,
  output logic [31:0] out_result_id,
  output logic [63:0] out_result_context,
  output logic        out_close_transport,
  output logic        out_last
);

  cst_cmd_t    cmd;
  cst_status_t sts;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cst_datapath #(
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_command            (in_command),
    .in_conn_id            (in_conn_id),
    .in_context_data       (in_context_data),
    .in_transport_valid    (in_transport_valid),
    .in_local_endpoint_ok  (in_local_endpoint_ok),
    .in_remote_endpoint_ok (in_remote_endpoint_ok),
    .in_family_match       (in_family_match),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_found             (out_found),
    .out_slot_index        (out_slot_index),
    .out_entry_state       (out_entry_state),
    .out_result_id         (out_result_id),
    .out_result_context    (out_result_context),
    .out_close_transport   (out_close_transport),
    .out_last              (out_last)
  );

endmodule
